// ===== rtl/rtlr_pkg.sv =====
// Package for the RLE tile row lookup: item structs, command kinds,
// status codes and configuration register indexes. No dependencies.
package rtlr_pkg;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  layer;
    logic [11:0] address;
    logic [12:0] write_value;
    logic        present;
    logic [15:0] x;
    logic [7:0]  y;
  } in_item_t;

  typedef struct packed {
    logic [15:0] tile;
    logic [2:0]  status;
  } out_item_t;

  localparam logic [1:0] OP_WR_OFFSET = 2'd0;
  localparam logic [1:0] OP_WR_RUN    = 2'd1;
  localparam logic [1:0] OP_SET_LAYER = 2'd2;
  localparam logic [1:0] OP_QUERY     = 2'd3;

  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_RANGE     = 3'd1;
  localparam logic [2:0] ST_ABSENT    = 3'd2;
  localparam logic [2:0] ST_BAD_OFFS  = 3'd3;
  localparam logic [2:0] ST_ZERO_RUN  = 3'd4;
  localparam logic [2:0] ST_ROW_END   = 3'd5;

  localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_EMPTY_TILE = 2'd2;

  typedef enum logic [2:0] {
    K_WR_OFFSET,
    K_WR_RUN,
    K_SET_LAYER,
    K_QUERY,
    K_RANGE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [2:0]  layer;
    logic [11:0] address;
    logic [12:0] write_value;
    logic        present;
    logic [15:0] x;
    logic [7:0]  y;
  } cmd_t;

  typedef struct packed {
    logic [15:0] map_width;
    logic [5:0]  map_height;
    logic [15:0] empty_tile;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/rtlr_front.sv =====
// Front end: accepts input words, drops ignored writes, flags out-of-range
// queries. Depends on rtlr_pkg.
module rtlr_front #(
  parameter int NUM_LAYERS = 4,
  parameter int MAX_ROWS   = 32,
  parameter int RUN_BYTES  = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rtlr_pkg::in_item_t in_data,
  input  rtlr_pkg::cfg_t    cfg,
  input  rtlr_pkg::q_stat_t q_stat,
  output logic              push,
  output rtlr_pkg::cmd_t    push_cmd
);

  logic           valid_r;
  rtlr_pkg::cmd_t cmd_r;
  rtlr_pkg::cmd_t cmd_nxt;
  logic           keep;
  logic           layer_ok;

  assign in_stall = valid_r && q_stat.full;
  assign push     = valid_r && !q_stat.full;
  assign push_cmd = cmd_r;

  always_comb begin
    layer_ok            = {1'b0, in_data.layer} < 4'(NUM_LAYERS);
    cmd_nxt.layer       = in_data.layer;
    cmd_nxt.address     = in_data.address;
    cmd_nxt.write_value = in_data.write_value;
    cmd_nxt.present     = in_data.present;
    cmd_nxt.x           = in_data.x;
    cmd_nxt.y           = in_data.y;
    keep                = layer_ok;
    unique case (in_data.opcode)
      rtlr_pkg::OP_WR_OFFSET: begin
        cmd_nxt.kind = rtlr_pkg::K_WR_OFFSET;
        keep = layer_ok && (17'(in_data.address) < 17'(MAX_ROWS + 1));
      end
      rtlr_pkg::OP_WR_RUN: begin
        cmd_nxt.kind = rtlr_pkg::K_WR_RUN;
        keep = layer_ok && (17'(in_data.address) < 17'(RUN_BYTES));
      end
      rtlr_pkg::OP_SET_LAYER: cmd_nxt.kind = rtlr_pkg::K_SET_LAYER;
      default: begin
        keep = 1'b1;
        if (!layer_ok || in_data.x >= cfg.map_width ||
            in_data.y >= {2'b00, cfg.map_height} ||
            9'(in_data.y) >= 9'(MAX_ROWS)) begin
          cmd_nxt.kind = rtlr_pkg::K_RANGE;
        end else begin
          cmd_nxt.kind = rtlr_pkg::K_QUERY;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      valid_r <= keep;
    end else if (!q_stat.full) begin
      valid_r <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

// ===== rtl/rtlr_fifo.sv =====
// Two-entry command queue between front and back end.
// Depends on rtlr_pkg.
module rtlr_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rtlr_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output rtlr_pkg::cmd_t    head,
  output rtlr_pkg::q_stat_t q_stat
);

  rtlr_pkg::cmd_t slot_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;

  assign head         = slot_r[rd_ptr_r];
  assign q_stat.full  = cnt_r == 2'd2;
  assign q_stat.empty = cnt_r == 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
    if (push) slot_r[wr_ptr_r] <= push_cmd;
  end

endmodule

// ===== rtl/rtlr_back.sv =====
// Back end: offset and run byte memories, layer info, row walk sequencer
// and output register. Depends on rtlr_pkg.
module rtlr_back #(
  parameter int NUM_LAYERS = 4,
  parameter int MAX_ROWS   = 32,
  parameter int RUN_BYTES  = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rtlr_pkg::q_stat_t q_stat,
  input  rtlr_pkg::cmd_t    head,
  output logic              pop,
  input  rtlr_pkg::cfg_t    cfg,
  output logic              out_valid,
  input  logic              out_stall,
  output rtlr_pkg::out_item_t out_data
);

  localparam int OFF_DEPTH = NUM_LAYERS * (MAX_ROWS + 1);
  localparam int OFF_AW    = $clog2(OFF_DEPTH);
  localparam int RUN_DEPTH = NUM_LAYERS * RUN_BYTES;
  localparam int RUN_AW    = $clog2(RUN_DEPTH);
  localparam int LW        = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_OFF0, S_OFF1, S_OFF2, S_CHK, S_LEN, S_LO, S_HI, S_EVAL, S_PUT
  } state_t;

  state_t      state_r;
  logic [12:0] off_mem [OFF_DEPTH];
  logic [7:0]  run_mem [RUN_DEPTH];
  logic [12:0] off_rd_r;
  logic [7:0]  run_rd_r;
  logic [12:0] size_r [NUM_LAYERS];
  logic        present_r [NUM_LAYERS];

  logic [LW-1:0] layer_r;
  logic [15:0]   x_r;
  logic [7:0]    y_r;
  logic [12:0]   cursor_r;
  logic [12:0]   end_r;
  logic [15:0]   column_r;
  logic [7:0]    len_r;
  logic [7:0]    lo_r;
  logic [15:0]   tile_r;
  logic [2:0]    st_r;
  logic          out_valid_r;
  rtlr_pkg::out_item_t out_r;

  logic [LW-1:0]   head_layer;
  logic [31:0]     off_calc;
  logic [31:0]     run_calc;
  logic [OFF_AW-1:0] off_addr;
  logic [RUN_AW-1:0] run_addr;
  logic [1:0]      run_step;
  logic [15:0]     col_sum;
  logic            off_we;
  logic            run_we;

  assign head_layer = head.layer[LW-1:0];
  assign pop        = (state_r == S_IDLE) && !q_stat.empty;
  assign off_we     = pop && (head.kind == rtlr_pkg::K_WR_OFFSET);
  assign run_we     = pop && (head.kind == rtlr_pkg::K_WR_RUN);
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;
  assign col_sum    = column_r + {8'h00, len_r};

  // One shared address per memory: writes at pop, reads during the walk.
  // Row start is addressed in S_OFF0, row end in S_OFF1 and S_OFF2.
  always_comb begin
    run_step = 2'd0;
    if (state_r == S_LO) run_step = 2'd1;
    if (state_r == S_HI) run_step = 2'd2;
    if (state_r == S_IDLE) begin
      off_calc = 32'(head_layer) * 32'(MAX_ROWS + 1) + 32'(head.address);
      run_calc = 32'(head_layer) * 32'(RUN_BYTES) + 32'(head.address);
    end else begin
      off_calc = 32'(layer_r) * 32'(MAX_ROWS + 1) + 32'(y_r) +
                 ((state_r == S_OFF1 || state_r == S_OFF2) ? 32'd1 : 32'd0);
      run_calc = 32'(layer_r) * 32'(RUN_BYTES) + 32'(cursor_r) + 32'(run_step);
    end
    off_addr = off_calc[OFF_AW-1:0];
    run_addr = run_calc[RUN_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (off_we) off_mem[off_addr] <= head.write_value;
    off_rd_r <= off_mem[off_addr];
    if (run_we) run_mem[run_addr] <= head.write_value[7:0];
    run_rd_r <= run_mem[run_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LAYERS; i++) begin
        size_r[i]    <= 13'd0;
        present_r[i] <= 1'b0;
      end
    end else if (pop && head.kind == rtlr_pkg::K_SET_LAYER) begin
      size_r[head_layer]    <= head.write_value;
      present_r[head_layer] <= head.present;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_PUT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (pop && head.kind == rtlr_pkg::K_QUERY) begin
            state_r <= S_OFF0;
          end else if (pop && head.kind == rtlr_pkg::K_RANGE) begin
            st_r    <= rtlr_pkg::ST_RANGE;
            state_r <= S_PUT;
          end
          layer_r <= head_layer;
          x_r     <= head.x;
          y_r     <= head.y;
        end
        S_OFF0: begin
          if (!present_r[layer_r]) begin
            st_r    <= rtlr_pkg::ST_ABSENT;
            state_r <= S_PUT;
          end else begin
            state_r <= S_OFF1;
          end
        end
        S_OFF1: begin
          cursor_r <= off_rd_r;
          state_r  <= S_OFF2;
        end
        S_OFF2: state_r <= S_CHK;
        S_CHK: begin
          end_r    <= off_rd_r;
          column_r <= 16'd0;
          if (off_rd_r > size_r[layer_r] || 17'(off_rd_r) > 17'(RUN_BYTES) ||
              cursor_r > off_rd_r) begin
            st_r    <= rtlr_pkg::ST_BAD_OFFS;
            state_r <= S_PUT;
          end else begin
            state_r <= S_LEN;
          end
        end
        S_LEN: begin
          if ({1'b0, cursor_r} + 14'd3 > {1'b0, end_r}) begin
            st_r    <= rtlr_pkg::ST_ROW_END;
            state_r <= S_PUT;
          end else begin
            state_r <= S_LO;
          end
        end
        S_LO: begin
          len_r   <= run_rd_r;
          state_r <= S_HI;
        end
        S_HI: begin
          lo_r    <= run_rd_r;
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          if (len_r == 8'd0) begin
            st_r    <= rtlr_pkg::ST_ZERO_RUN;
            state_r <= S_PUT;
          end else if (x_r < col_sum) begin
            st_r    <= rtlr_pkg::ST_FOUND;
            tile_r  <= {run_rd_r, lo_r};
            state_r <= S_PUT;
          end else begin
            column_r <= col_sum;
            cursor_r <= cursor_r + 13'd3;
            state_r  <= S_LEN;
          end
        end
        S_PUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r   <= 1'b1;
            out_r.status  <= st_r;
            out_r.tile    <= (st_r == rtlr_pkg::ST_FOUND) ? tile_r : cfg.empty_tile;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/rle_tile_row_lookup.sv =====
// Top level of the RLE tile row lookup: configuration registers, front end,
// command queue and back end. Depends on rtlr_pkg and the rtlr_* modules.
//
// Load words (row offset, run byte, layer info) are written in the back
// end at pop; writes to a missing layer or past the offset or run store
// are dropped at the front. A query passes the front register and queue,
// reads the row start and end offsets, then visits run after run (3 run
// byte reads and one compare each) until it finds the column or the row
// ends; the single-port run byte memory, read one byte a cycle, sets the
// pace. One query is walked at a time; the front and the two-entry queue
// keep taking words while it runs, until the queue is full, and a finished
// result waits in the output register. Memories need no clearing pass
// after reset; layer size and present flags reset to zero. Configuration
// writes take effect at once and are meant for idle periods only.
module rle_tile_row_lookup #(
  parameter int NUM_LAYERS = 4,
  parameter int MAX_ROWS   = 32,
  parameter int RUN_BYTES  = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rtlr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rtlr_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);

  rtlr_pkg::cfg_t    cfg_r;
  rtlr_pkg::q_stat_t q_stat;
  rtlr_pkg::cmd_t    push_cmd;
  rtlr_pkg::cmd_t    head;
  logic              push;
  logic              pop;

  // Hold configuration; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rtlr_pkg::CFG_MAP_WIDTH:  cfg_r.map_width  <= cfg_wdata;
        rtlr_pkg::CFG_MAP_HEIGHT: cfg_r.map_height <= cfg_wdata[5:0];
        rtlr_pkg::CFG_EMPTY_TILE: cfg_r.empty_tile <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Classify words and drop ignored writes.
  rtlr_front #(
    .NUM_LAYERS(NUM_LAYERS), .MAX_ROWS(MAX_ROWS), .RUN_BYTES(RUN_BYTES)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .cfg(cfg_r), .q_stat(q_stat), .push(push),
    .push_cmd(push_cmd)
  );

  // Decouple front from the row walk.
  rtlr_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_cmd(push_cmd), .pop(pop),
    .head(head), .q_stat(q_stat)
  );

  // Carry out loads and walk rows.
  rtlr_back #(
    .NUM_LAYERS(NUM_LAYERS), .MAX_ROWS(MAX_ROWS), .RUN_BYTES(RUN_BYTES)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_stat(q_stat), .head(head), .pop(pop),
    .cfg(cfg_r), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= rtlr_pkg::ST_ROW_END)
    else $error("status code out of range");

  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty at once");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push)
    else $error("push into full queue");

endmodule
